FILE: rtl/core/first_fit_heap_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Shared helpers for the checker; every property runs on clk with rst_n low
// disabling it.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define FFHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication from a trigger to a condition, checked with the non-overlapping |=> operator.
`define FFHA_ASSERT_NEXT(lbl, trig, cond, msg) \
  `FFHA_ASSERT(lbl, (trig) |=> (cond), msg)

`endif

FILE: rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// Package for the first-fit heap allocator
// Shared types, codes and defaults.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 65536;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_BAD_PTR = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_EV,
    S_SPLIT,
    S_NRD,
    S_NEV
  } state_t;

endpackage

FILE: rtl/core/first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Implicit free list in a header memory, one header per 16-byte slot, walked
// by a small sequencer.
//
// Channel  Dir  tdata (low bit up)                     tuser
// in_      in   request_bytes[15:0], payload_offset    kind
// out_     out  granted_offset[15:0]                   status[1:0]
//
// Per header visited an item takes a read and an evaluation, plus a split step
// if it splits and a next-block read and evaluation on free. A bad-alignment
// free is answered from idle without a header read. The single-port header
// read sets the pace. After reset, an init state writes the first header
// before in_tready. A new item is taken only when the result register is empty.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_bytes[15:0], payload_offset[31:16]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // granted_offset[15:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int unsigned SLOT_COUNT = HEAP_BYTES / 16;
  localparam int unsigned AW         = $clog2(SLOT_COUNT);
  localparam int unsigned CW         = (AW + 1 > 13) ? AW + 1 : 13;
  localparam logic [AW:0] END_SLOT   = (AW+1)'(SLOT_COUNT - 1);

  logic [AW:0] mem [SLOT_COUNT];

  ffha_pkg::state_t state_r, state_nxt;
  logic [AW:0]   s_r, s_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [AW-1:0] prev_slots_r, prev_slots_nxt;
  logic          prev_free_r, prev_free_nxt;
  logic          has_prev_r, has_prev_nxt;
  logic          kind_r, kind_nxt;
  logic [CW-1:0] need_r, need_nxt;
  logic [CW-1:0] target_r, target_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW:0]   rdata_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW:0]   wr_data;
  logic          res_en;
  logic [1:0]    res_status;
  logic [15:0]   res_offset;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [15:0]   out_offset_r;

  logic          h_used;
  logic [AW-1:0] h_slots;
  logic [AW:0]   s_adv;
  logic [AW:0]   n_slot;
  logic          fit, split, hit;
  logic [AW-1:0] merged;
  logic [31:0]   grant_wide;
  logic [16:0]   need_sum;
  logic          accept;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == ffha_pkg::S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_offset_r;
  assign out_tuser  = out_status_r;

  assign h_used     = rdata_r[AW];
  assign h_slots    = rdata_r[AW-1:0];
  assign s_adv      = s_r + {1'b0, h_slots};
  assign n_slot     = s_r + {1'b0, cur_r};
  assign fit        = !h_used && (CW'(h_slots) >= need_r);
  assign split      = CW'(h_slots) > need_r;
  assign hit        = CW'(s_r) == target_r;
  assign merged     = cur_r + (h_used ? '0 : h_slots);
  assign grant_wide = (32'(s_r) << 4) | 32'd8;
  assign need_sum   = {1'b0, in_tdata[15:0]} + 17'd23;
  assign rd_addr    = (state_r == ffha_pkg::S_NRD) ? n_slot[AW-1:0] : s_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffha_pkg::S_INIT: state_nxt = ffha_pkg::S_IDLE;
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          if (in_tuser == ffha_pkg::KIND_FREE && in_tdata[19:16] != 4'd8) begin
            state_nxt = ffha_pkg::S_IDLE;
          end else begin
            state_nxt = ffha_pkg::S_RD;
          end
        end
      end
      ffha_pkg::S_RD: state_nxt = ffha_pkg::S_EV;
      ffha_pkg::S_EV: begin
        if (kind_r == ffha_pkg::KIND_ALLOC) begin
          if (fit) begin
            state_nxt = split ? ffha_pkg::S_SPLIT : ffha_pkg::S_IDLE;
          end else if (s_adv >= END_SLOT) begin
            state_nxt = ffha_pkg::S_IDLE;
          end else begin
            state_nxt = ffha_pkg::S_RD;
          end
        end else begin
          if (hit) begin
            if (!h_used || s_adv >= END_SLOT) begin
              state_nxt = ffha_pkg::S_IDLE;
            end else begin
              state_nxt = ffha_pkg::S_NRD;
            end
          end else if (s_adv >= END_SLOT) begin
            state_nxt = ffha_pkg::S_IDLE;
          end else begin
            state_nxt = ffha_pkg::S_RD;
          end
        end
      end
      ffha_pkg::S_SPLIT: state_nxt = ffha_pkg::S_IDLE;
      ffha_pkg::S_NRD:   state_nxt = ffha_pkg::S_NEV;
      ffha_pkg::S_NEV:   state_nxt = ffha_pkg::S_IDLE;
      default:           state_nxt = ffha_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory writes and results.
  always_comb begin
    s_nxt          = s_r;
    prev_nxt       = prev_r;
    prev_slots_nxt = prev_slots_r;
    prev_free_nxt  = prev_free_r;
    has_prev_nxt   = has_prev_r;
    kind_nxt       = kind_r;
    need_nxt       = need_r;
    target_nxt     = target_r;
    cur_nxt        = cur_r;
    wr_en          = 1'b0;
    wr_addr        = s_r[AW-1:0];
    wr_data        = '0;
    res_en         = 1'b0;
    res_status     = ffha_pkg::ST_OK;
    res_offset     = '0;
    unique case (state_r)
      ffha_pkg::S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {1'b0, END_SLOT[AW-1:0]};
      end
      ffha_pkg::S_IDLE: begin
        if (accept) begin
          kind_nxt     = in_tuser;
          need_nxt     = CW'(need_sum[16:4]);
          target_nxt   = CW'(in_tdata[31:20]);
          s_nxt        = '0;
          has_prev_nxt = 1'b0;
          if (in_tuser == ffha_pkg::KIND_FREE && in_tdata[19:16] != 4'd8) begin
            res_en     = 1'b1;
            res_status = ffha_pkg::ST_BAD_PTR;
          end
        end
      end
      ffha_pkg::S_EV: begin
        if (kind_r == ffha_pkg::KIND_ALLOC) begin
          if (fit) begin
            res_en     = 1'b1;
            res_offset = grant_wide[15:0];
            wr_en      = 1'b1;
            if (split) begin
              wr_addr = AW'(CW'(s_r) + need_r);
              wr_data = {1'b0, AW'(CW'(h_slots) - need_r)};
            end else begin
              wr_data = {1'b1, h_slots};
            end
          end else begin
            s_nxt = s_adv;
            if (s_adv >= END_SLOT) begin
              res_en     = 1'b1;
              res_status = ffha_pkg::ST_NO_FIT;
            end
          end
        end else begin
          if (hit) begin
            cur_nxt = h_slots;
            if (h_used) begin
              if (s_adv >= END_SLOT) begin
                // No next block to merge: free this block, merging into a free previous one.
                res_en  = 1'b1;
                wr_en   = 1'b1;
                if (has_prev_r && prev_free_r) begin
                  wr_addr = prev_r;
                  wr_data = {1'b0, prev_slots_r + h_slots};
                end else begin
                  wr_data = {1'b0, h_slots};
                end
              end
            end else begin
              res_en     = 1'b1;
              res_status = ffha_pkg::ST_BAD_PTR;
            end
          end else begin
            prev_nxt       = s_r[AW-1:0];
            prev_slots_nxt = h_slots;
            prev_free_nxt  = !h_used;
            has_prev_nxt   = 1'b1;
            s_nxt          = s_adv;
            if (s_adv >= END_SLOT) begin
              res_en     = 1'b1;
              res_status = ffha_pkg::ST_BAD_PTR;
            end
          end
        end
      end
      ffha_pkg::S_SPLIT: begin
        wr_en   = 1'b1;
        wr_data = {1'b1, need_r[AW-1:0]};
      end
      ffha_pkg::S_NEV: begin
        res_en = 1'b1;
        wr_en  = 1'b1;
        if (has_prev_r && prev_free_r) begin
          wr_addr = prev_r;
          wr_data = {1'b0, prev_slots_r + merged};
        end else begin
          wr_data = {1'b0, merged};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffha_pkg::S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_en) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r          <= s_nxt;
    prev_r       <= prev_nxt;
    prev_slots_r <= prev_slots_nxt;
    prev_free_r  <= prev_free_nxt;
    has_prev_r   <= has_prev_nxt;
    kind_r       <= kind_nxt;
    need_r       <= need_nxt;
    target_r     <= target_nxt;
    cur_r        <= cur_nxt;
    if (res_en) begin
      out_status_r <= res_status;
      out_offset_r <= res_offset;
    end
  end

endmodule

FILE: rtl/core/ffha_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the first-fit heap allocator
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_top_macros.svh"

module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `FFHA_ASSERT(a_status_code, !out_tvalid || out_tuser <= ffha_pkg::ST_BAD_PTR, "bad status")
  `FFHA_ASSERT(a_fail_zero, !out_tvalid || out_tuser == ffha_pkg::ST_OK || out_tdata == '0, "offset")
  `FFHA_ASSERT(a_busy_with_result, !(out_tvalid && in_tready), "input ready while a result waits")
  `FFHA_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/tb_first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// Testbench for the first-fit heap allocator
// Drives allocate and free requests on the input stream and predicts each
// status and granted offset from an in-bench copy of the block header list.
// Starts with directed corner cases, then random allocations and frees of
// live, freed and random pointers; both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_top;

  localparam int unsigned SLOTS   = ffha_pkg::HEAP_BYTES_DEF / 16;
  localparam int unsigned END_IDX = SLOTS - 1;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted;
  } alloc_result_t;

  class heap_scoreboard;
    int unsigned   blk_slots[SLOTS];
    bit            blk_used[SLOTS];
    alloc_result_t pending_results[$];
    int            errors;
    int            checked;

    function void clear_heap();
      foreach (blk_slots[i]) begin
        blk_slots[i] = 0;
        blk_used[i]  = 0;
      end
      blk_slots[0]       = END_IDX;
      blk_used[END_IDX]  = 1;
      errors  = 0;
      checked = 0;
    endfunction

    function alloc_result_t predict_alloc(int unsigned req);
      alloc_result_t r;
      int unsigned need, s, guard;
      need  = (req + 23) / 16;
      s     = 0;
      guard = 0;
      r     = '{ffha_pkg::ST_NO_FIT, 16'd0};
      while (s < END_IDX && guard < SLOTS) begin
        if (blk_slots[s] == 0) break;
        if (!blk_used[s] && blk_slots[s] >= need) begin
          // Split off the tail when at least one whole slot is left over.
          if (blk_slots[s] >= need + 1) begin
            blk_slots[s + need] = blk_slots[s] - need;
            blk_used[s + need]  = 0;
            blk_slots[s]        = need;
          end
          blk_used[s] = 1;
          r = '{ffha_pkg::ST_OK, 16'(s * 16 + 8)};
          return r;
        end
        s += blk_slots[s];
        guard++;
      end
      return r;
    endfunction

    function alloc_result_t predict_free(logic [15:0] off);
      alloc_result_t r;
      int unsigned s, prev, guard, target, nxt;
      bit has_prev;
      r = '{ffha_pkg::ST_BAD_PTR, 16'd0};
      if (off[3:0] != 4'd8) return r;
      target   = off >> 4;
      s        = 0;
      prev     = 0;
      has_prev = 0;
      guard    = 0;
      while (s < END_IDX && guard < SLOTS) begin
        if (blk_slots[s] == 0) break;
        if (s == target) begin
          if (!blk_used[s]) return r;
          blk_used[s] = 0;
          nxt = s + blk_slots[s];
          if (nxt < END_IDX && !blk_used[nxt]) blk_slots[s] += blk_slots[nxt];
          if (has_prev && !blk_used[prev]) blk_slots[prev] += blk_slots[s];
          r = '{ffha_pkg::ST_OK, 16'd0};
          return r;
        end
        prev     = s;
        has_prev = 1;
        s += blk_slots[s];
        guard++;
      end
      return r;
    endfunction

    function alloc_result_t note_request(logic kind, logic [15:0] req, logic [15:0] off);
      alloc_result_t r;
      r = (kind == ffha_pkg::KIND_ALLOC) ? predict_alloc(req) : predict_free(off);
      pending_results.push_back(r);
      return r;
    endfunction

    function void check_result(logic [1:0] status, logic [15:0] granted);
      alloc_result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d offset=%0d", $realtime, status, granted);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      checked++;
      if (status !== exp_r.status) begin
        $display("%0t: status mismatch expected %0d actual %0d",
                 $realtime, exp_r.status, status);
        errors++;
      end
      if (granted !== exp_r.granted) begin
        $display("%0t: granted_offset mismatch expected %0d actual %0d",
                 $realtime, exp_r.granted, granted);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  first_fit_heap_allocator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  heap_scoreboard sb;
  logic [15:0]    live_ptrs[$];
  logic [15:0]    freed_ptrs[$];
  bit             busy_burst;
  int             stall_left = 0;
  int             n_alloc_ok, n_free_ok, n_no_fit, n_bad_ptr;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #(4 * 4_000_000);
    $display("Timeout waiting for the allocator");
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: check every transfer, then draw the next stall.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tuser, out_tdata);
        stall_left = busy_burst ? 0 : $urandom_range(0, 10);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_tready <= (stall_left == 0);
    end
  end

  task automatic send_request(logic kind, logic [15:0] req, logic [15:0] off);
    int gap;
    alloc_result_t r;
    gap = busy_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {off, req};
    do @(posedge clk); while (!in_tready);
    r = sb.note_request(kind, req, off);
    case (r.status)
      ffha_pkg::ST_OK: begin
        if (kind == ffha_pkg::KIND_ALLOC) begin
          live_ptrs.push_back(r.granted);
          n_alloc_ok++;
        end else begin
          foreach (live_ptrs[i]) if (live_ptrs[i] == off) begin
            live_ptrs.delete(i);
            break;
          end
          freed_ptrs.push_back(off);
          if (freed_ptrs.size() > 16) void'(freed_ptrs.pop_front());
          n_free_ok++;
        end
      end
      ffha_pkg::ST_NO_FIT: n_no_fit++;
      default:   n_bad_ptr++;
    endcase
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_request();
    int pick, idx;
    logic [15:0] req;
    pick = $urandom_range(0, 99);
    if (live_ptrs.size() >= 40 || (live_ptrs.size() > 0 && pick < 45)) begin
      idx = $urandom_range(0, live_ptrs.size() - 1);
      send_request(ffha_pkg::KIND_FREE, 16'($urandom), live_ptrs[idx]);
    end else if (pick < 55 && freed_ptrs.size() > 0) begin
      // Double free, or a pointer that may now point inside a merged block.
      idx = $urandom_range(0, freed_ptrs.size() - 1);
      send_request(ffha_pkg::KIND_FREE, 16'($urandom), freed_ptrs[idx]);
    end else if (pick < 62) begin
      send_request(ffha_pkg::KIND_FREE, 16'($urandom), 16'($urandom));
    end else begin
      if (pick < 70) req = 16'($urandom);
      else if (pick < 74) req = 16'($urandom_range(0, 4000));
      else req = 16'($urandom_range(0, 300));
      send_request(ffha_pkg::KIND_ALLOC, req, 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.clear_heap();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = ffha_pkg::KIND_ALLOC;
    out_tready = 1'b0;
    busy_burst = 0;
    n_alloc_ok = 0;
    n_free_ok  = 0;
    n_no_fit   = 0;
    n_bad_ptr  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Nearly the whole heap in one block, then the one-slot tail left over.
    send_request(ffha_pkg::KIND_ALLOC, 16'd65496, 16'hFFFF);
    send_request(ffha_pkg::KIND_ALLOC, 16'd0, 16'h0000);
    send_request(ffha_pkg::KIND_FREE, 16'hFFFF, 16'd8);
    send_request(ffha_pkg::KIND_FREE, 16'h0000, 16'd8);
    // Oversized requests while the one-slot tail block is still allocated.
    send_request(ffha_pkg::KIND_ALLOC, 16'd65520, 16'd0);
    send_request(ffha_pkg::KIND_ALLOC, 16'hFFFF, 16'd0);
    // Small blocks, including zero-length payload.
    send_request(ffha_pkg::KIND_ALLOC, 16'd0, 16'd0);
    send_request(ffha_pkg::KIND_ALLOC, 16'd1, 16'd0);
    send_request(ffha_pkg::KIND_ALLOC, 16'd8, 16'd0);
    send_request(ffha_pkg::KIND_ALLOC, 16'd9, 16'd0);
    send_request(ffha_pkg::KIND_ALLOC, 16'd100, 16'd0);
    // Free with no merge, merge with previous, merge with next, free inside a block.
    send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd24);
    send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd40);
    send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd8);
    send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd72);
    // Bad pointers: end marker, then misaligned: 7, 16, all ones, zero.
    send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd65528);
    send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd7);
    send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd16);
    send_request(ffha_pkg::KIND_FREE, 16'd0, 16'hFFFF);
    send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd0);
    send_request(ffha_pkg::KIND_ALLOC, 16'd40, 16'd0);
    send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd8);
    wait_drained();
    live_ptrs.delete();
    foreach (sb.blk_slots[i]) if (sb.blk_used[i] && i != END_IDX)
      live_ptrs.push_back(16'(i * 16 + 8));

    for (int k = 0; k < 1500; k++) begin
      if (k % 100 == 0) busy_burst = ($urandom_range(0, 3) == 0);
      if (k == 700) wait_drained();
      random_request();
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("Covered %0d results: %0d allocations, %0d frees, %0d no-fit, %0d bad pointer.",
             sb.checked, n_alloc_ok, n_free_ok, n_no_fit, n_bad_ptr);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
